>>> hdl/sorted_event_track_range_query_defines.svh
// Assertion macros shared by the sorted event track RTL.
`ifndef SORTED_EVENT_TRACK_RANGE_QUERY_DEFINES_SVH
`define SORTED_EVENT_TRACK_RANGE_QUERY_DEFINES_SVH

// Same-cycle implication under a synchronous active-low reset.
`define SETRQ_CHECK_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("setrq: check failed");

// Next-cycle implication under a synchronous active-low reset.
`define SETRQ_CHECK_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("setrq: check failed");

`endif

>>> hdl/setrq_pkg.sv
// Types and constants of the sorted event track range query.
`timescale 1ns / 1ps

package setrq_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int MAX_EVENTS     = 256;
    localparam int OUT_LIMIT      = 64;
    localparam int NW             = $clog2(OUT_LIMIT + 1);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [1:0] STAT_EVENT = 2'd0;
    localparam logic [1:0] STAT_ACK   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_START,
        ST_INS_CHK,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [31:0] tstamp;
        logic [7:0]         ev;
    } t_entry;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] ev;
        logic [1:0] status;
        logic       last;
    } t_out_req;

endpackage

>>> hdl/setrq_table.sv
// Point table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module setrq_table import setrq_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int AW         = $clog2(DEF_MAX_POINTS)
) (
    input  logic          i_clk,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [MAX_POINTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/setrq_out.sv
// Output register for result words.
`timescale 1ns / 1ps

module setrq_out import setrq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_out_req   i_req,
    output logic       o_free,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_found_event,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_ev;
    logic [1:0] r_status;
    logic       r_last;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_req.valid) begin
            r_ev     <= i_req.ev;
            r_status <= i_req.status;
            r_last   <= i_req.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_found_event = r_ev;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

>>> hdl/sorted_event_track_range_query.sv
// Top level: sequencer over the sorted point table and result output.
//
//  channel  direction  handshake                   word
//  in       sink       i_in_valid / o_in_ready     kind, time_or_start, range_end, event_id
//  out      source     o_out_valid / i_out_ready   found_event, status, last
//
// One item at a time; o_in_ready is high in the idle state only.
// Clear, unused kind, rejected add and sample of an empty table go straight to ST_FIN.
// Add: ST_INS_START/ST_INS_CHK shift later entries up one place, then write the new one.
// Sample: the table read port gives one entry a cycle to ST_SCAN unless the output stalls.
// A stalled output holds the scan only when a second match is waiting.
// Synchronous reset empties the table at once; no clearing pass.
`timescale 1ns / 1ps
`include "sorted_event_track_range_query_defines.svh"

module sorted_event_track_range_query import setrq_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_time_or_start,
    input  logic signed [31:0] i_range_end,
    input  logic [7:0]         i_event_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_found_event,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic [7:0]         r_ev, n_ev;
    logic [AW-1:0]      r_h, n_h;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_left, n_left;
    logic               r_dv, n_dv;
    logic               r_back, n_back;
    logic [NW-1:0]      r_n, n_n;
    logic               r_pend_valid, n_pend_valid;
    logic [7:0]         r_pend_ev, n_pend_ev;
    logic [1:0]         r_fin_status, n_fin_status;

    t_tbl_ctl      tbl_ctl;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    t_out_req      out_req;
    logic          out_free;
    logic          match;
    logic          consume;

    setrq_table #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    setrq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (out_req),
        .o_free        (out_free),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found_event (o_found_event),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_ev         <= n_ev;
        r_h          <= n_h;
        r_idx        <= n_idx;
        r_left       <= n_left;
        r_dv         <= n_dv;
        r_back       <= n_back;
        r_n          <= n_n;
        r_pend_valid <= n_pend_valid;
        r_pend_ev    <= n_pend_ev;
        r_fin_status <= n_fin_status;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_a          = r_a;
        n_b          = r_b;
        n_ev         = r_ev;
        n_h          = r_h;
        n_idx        = r_idx;
        n_left       = r_left;
        n_dv         = r_dv;
        n_back       = r_back;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend_ev    = r_pend_ev;
        n_fin_status = r_fin_status;
        tbl_ctl      = '0;
        wr_addr      = r_h;
        wr_data      = '{tstamp: r_a, ev: r_ev};
        rd_addr      = r_idx;
        out_req      = '0;
        o_in_ready   = 1'b0;
        consume      = 1'b0;

        if (r_back) begin
            match = ($signed(rd_data.tstamp) <= r_a) && ($signed(rd_data.tstamp) > r_b);
        end else begin
            match = ($signed(rd_data.tstamp) >= r_a) && ($signed(rd_data.tstamp) < r_b);
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_a          = i_time_or_start;
                    n_b          = i_range_end;
                    n_ev         = 8'(32'(i_event_id) % MAX_EVENTS);
                    n_pend_valid = 1'b0;
                    n_fin_status = STAT_ACK;
                    n_state      = ST_FIN;
                    case (i_kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        KIND_ADD: begin
                            if (r_count == CW'(MAX_POINTS)) begin
                                n_fin_status = STAT_FULL;
                            end else begin
                                n_h     = r_count[AW-1:0];
                                n_state = ST_INS_START;
                            end
                        end
                        KIND_SAMPLE: begin
                            if (r_count != '0) begin
                                n_back  = i_time_or_start > i_range_end;
                                n_idx   = (i_time_or_start > i_range_end)
                                          ? AW'(r_count - CW'(1)) : '0;
                                n_left  = r_count;
                                n_dv    = 1'b0;
                                n_n     = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS_START: begin
                if (r_h == '0) begin
                    tbl_ctl.wr_en = 1'b1;
                    n_count       = r_count + CW'(1);
                    n_state       = ST_FIN;
                end else begin
                    tbl_ctl.rd_en = 1'b1;
                    rd_addr       = r_h - AW'(1);
                    n_state       = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                tbl_ctl.wr_en = 1'b1;
                if ($signed(rd_data.tstamp) > r_a) begin
                    wr_data = rd_data;
                    n_h     = r_h - AW'(1);
                    if (r_h == AW'(1)) begin
                        n_state = ST_INS_START;
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        rd_addr       = r_h - AW'(2);
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (r_n == NW'(OUT_LIMIT) || (r_left == '0 && !r_dv)) begin
                    n_state = ST_FIN;
                end else begin
                    consume = r_dv && (!match || !r_pend_valid || out_free);
                    if (consume && match) begin
                        if (r_pend_valid) begin
                            out_req = '{valid: 1'b1, ev: r_pend_ev, status: STAT_EVENT,
                                        last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_ev    = rd_data.ev;
                        n_n          = r_n + NW'(1);
                    end
                    if (r_left != '0 && (!r_dv || consume)) begin
                        tbl_ctl.rd_en = 1'b1;
                        n_idx         = r_back ? r_idx - AW'(1) : r_idx + AW'(1);
                        n_left        = r_left - CW'(1);
                        n_dv          = 1'b1;
                    end else if (consume) begin
                        n_dv = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (r_pend_valid) begin
                        out_req = '{valid: 1'b1, ev: r_pend_ev, status: STAT_EVENT,
                                    last: 1'b1};
                    end else begin
                        out_req = '{valid: 1'b1, ev: 8'd0, status: r_fin_status,
                                    last: 1'b1};
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SETRQ_CHECK_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS))
    `SETRQ_CHECK_IMP(a_limit_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_n <= NW'(OUT_LIMIT))
    `SETRQ_CHECK_IMP(a_ack_no_event, i_clk, i_rst_n, o_out_valid && o_status != STAT_EVENT, o_found_event == 8'd0)
    `SETRQ_CHECK_NXT(a_clear_empties, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind == KIND_CLEAR, r_count == '0)
    `SETRQ_CHECK_NXT(a_add_inserts, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind == KIND_ADD && r_count != CW'(MAX_POINTS), r_state == ST_INS_START)

endmodule

>>> verif/tb_sorted_event_track_range_query.sv
// Self-checking testbench for the sorted event track range query block.
`timescale 1ns / 1ps

module tb_sorted_event_track_range_query;
    import setrq_pkg::*;

    localparam int                 TRACK_DEPTH   = DEF_MAX_POINTS;
    localparam logic [1:0]         KIND_RESERVED = 2'd3;
    localparam logic signed [31:0] T_MIN         = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX         = 32'sh7FFF_FFFF;
    localparam int                 STALL_LIMIT   = 2000;
    localparam int                 DRAIN_CYCLES  = 100;
    localparam int                 N_DIRECTED    = 22;

    typedef struct packed {
        logic [7:0] ev;
        logic [1:0] status;
        logic       last;
    } hit_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic [7:0]         ev;
        logic               typed;
        logic [1:0]         status;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_SAMPLE,   32'sd0,  32'sd100, 8'h00, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   T_MAX,   T_MIN,    8'h00, 1'b1, STAT_ACK},
        '{KIND_RESERVED, 32'sd7,  32'sd9,   8'h42, 1'b1, STAT_ACK},
        '{KIND_ADD,      T_MIN,   32'sd0,   8'h00, 1'b1, STAT_ACK},
        '{KIND_ADD,      T_MAX,   32'sd0,   8'hFF, 1'b1, STAT_ACK},
        '{KIND_ADD,      32'sd5,  32'sd0,   8'h5A, 1'b1, STAT_ACK},
        '{KIND_ADD,      32'sd5,  32'sd0,   8'hA5, 1'b1, STAT_ACK},
        '{KIND_ADD,      -32'sd3, 32'sd0,   8'h11, 1'b1, STAT_ACK},
        '{KIND_ADD,      32'sd5,  32'sd0,   8'h33, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   T_MIN,   T_MAX,    8'h00, 1'b0, STAT_ACK},
        '{KIND_SAMPLE,   T_MAX,   T_MIN,    8'h00, 1'b0, STAT_ACK},
        '{KIND_SAMPLE,   32'sd5,  32'sd6,   8'h00, 1'b0, STAT_ACK},
        '{KIND_SAMPLE,   32'sd5,  32'sd4,   8'h00, 1'b0, STAT_ACK},
        '{KIND_SAMPLE,   32'sd5,  32'sd5,   8'h00, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   32'sd6,  32'sd100, 8'h00, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   -32'sd3, T_MIN,    8'h00, 1'b0, STAT_ACK},
        '{KIND_RESERVED, -32'sd1, -32'sd1,  8'hFF, 1'b1, STAT_ACK},
        '{KIND_CLEAR,    32'sd5,  32'sd6,   8'h5A, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   T_MIN,   T_MAX,    8'h00, 1'b1, STAT_ACK},
        '{KIND_ADD,      32'sd0,  32'sd0,   8'h80, 1'b1, STAT_ACK},
        '{KIND_SAMPLE,   32'sd0,  32'sd1,   8'h00, 1'b0, STAT_ACK},
        '{KIND_CLEAR,    32'sd0,  32'sd0,   8'h00, 1'b1, STAT_ACK}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic signed [31:0] time_or_start;
    logic signed [31:0] range_end;
    logic [7:0]         event_id;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         found_event;
    logic [1:0]         status;
    logic               last;

    logic signed [31:0] track_times [TRACK_DEPTH];
    logic [7:0]         track_ids   [TRACK_DEPTH];
    int                 track_count;
    hit_t               step_hits [$];
    hit_t               expected_hits [$];
    hit_t               want_hit;
    int                 mismatches;
    int                 stall_cycles;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    sorted_event_track_range_query dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_time_or_start (time_or_start),
        .i_range_end     (range_end),
        .i_event_id      (event_id),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_found_event   (found_event),
        .o_status        (status),
        .o_last          (last)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic track_update(input logic [1:0] k, input logic signed [31:0] a,
                                input logic signed [31:0] b, input logic [7:0] ev);
        int pos;
        step_hits.delete();
        case (k)
            KIND_CLEAR: track_count = 0;
            KIND_ADD: begin
                if (track_count >= TRACK_DEPTH) begin
                    step_hits.push_back(hit_t'{ev: 8'h00, status: STAT_FULL, last: 1'b1});
                    return;
                end
                pos = track_count;
                while (pos > 0 && track_times[pos - 1] > a) begin
                    track_times[pos] = track_times[pos - 1];
                    track_ids[pos]   = track_ids[pos - 1];
                    pos--;
                end
                track_times[pos] = a;
                track_ids[pos]   = ev;
                track_count++;
            end
            KIND_SAMPLE: begin
                if (a <= b) begin
                    for (int i = 0; i < track_count && step_hits.size() < OUT_LIMIT; i++)
                        if (track_times[i] >= a && track_times[i] < b)
                            step_hits.push_back(hit_t'{ev: track_ids[i], status: STAT_EVENT,
                                                       last: 1'b0});
                end else begin
                    for (int i = track_count - 1; i >= 0 && step_hits.size() < OUT_LIMIT; i--)
                        if (track_times[i] <= a && track_times[i] > b)
                            step_hits.push_back(hit_t'{ev: track_ids[i], status: STAT_EVENT,
                                                       last: 1'b0});
                end
            end
            default: ;
        endcase
        if (step_hits.size() == 0)
            step_hits.push_back(hit_t'{ev: 8'h00, status: STAT_ACK, last: 1'b1});
        else
            step_hits[step_hits.size() - 1].last = 1'b1;
    endtask

    task automatic send_word(input logic [1:0] k, input logic signed [31:0] a,
                             input logic signed [31:0] b, input logic [7:0] ev,
                             input logic typed, input logic [1:0] typed_status);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        time_or_start <= a;
        range_end     <= b;
        event_id      <= ev;
        do @(posedge i_clk); while (!in_ready);
        track_update(k, a, b, ev);
        if (typed)
            expected_hits.push_back(hit_t'{ev: 8'h00, status: typed_status, last: 1'b1});
        else
            foreach (step_hits[i]) expected_hits.push_back(step_hits[i]);
    endtask

    function automatic logic signed [31:0] pick_time();
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 6) begin
            v = int'($urandom_range(40)) - 20;
            return v;
        end
        if (r == 6)
            return ($urandom_range(1) != 0) ? T_MAX : T_MIN;
        return $urandom;
    endfunction

    task automatic send_random(input int count);
        int r;
        logic [1:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            k = (r < 4) ? KIND_CLEAR : (r < 6) ? KIND_RESERVED : (r < 55) ? KIND_ADD
                                                                           : KIND_SAMPLE;
            send_word(k, pick_time(), pick_time(), 8'($urandom), 1'b0, STAT_ACK);
        end
    endtask

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: event %0d status %0d last %0d",
                             found_event, status, last);
            end else begin
                want_hit = expected_hits.pop_front();
                if (want_hit != hit_t'{ev: found_event, status: status, last: last}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected event %0d status %0d last %0d, got event %0d status %0d last %0d",
                                 want_hit.ev, want_hit.status, want_hit.last,
                                 found_event, status, last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_CLEAR;
        time_or_start = '0;
        range_end     = '0;
        event_id      = '0;
        out_ready     = 1'b0;
        track_count   = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        send_idle_pct = 17;
        recv_idle_pct = 69;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].kind, DIRECTED[i].t0, DIRECTED[i].t1, DIRECTED[i].ev,
                      DIRECTED[i].typed, DIRECTED[i].status);
        send_random(5);

        send_idle_pct = 69;
        recv_idle_pct = 17;
        send_random(5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // fill the table past capacity, then sample it heavily
        send_word(KIND_CLEAR, 32'sd0, 32'sd0, 8'h00, 1'b0, STAT_ACK);
        for (int n = 0; n < TRACK_DEPTH + 3; n++)
            send_word(KIND_ADD, pick_time(), pick_time(), 8'($urandom), 1'b0, STAT_ACK);
        send_word(KIND_SAMPLE, T_MIN, T_MAX, 8'h00, 1'b0, STAT_ACK);
        send_word(KIND_SAMPLE, T_MAX, T_MIN, 8'h00, 1'b0, STAT_ACK);
        for (int n = 0; n < 6; n++)
            send_word(KIND_SAMPLE, pick_time(), pick_time(), 8'($urandom), 1'b0, STAT_ACK);
        in_valid <= 1'b0;

        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
